[sv/assert_macros.svh]
// Assertion macros shared by the automaton RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/dsa_pkg.sv]
// Shared codes, field widths and stage type of the automaton.
package dsa_pkg;

    localparam int CMD_W   = 3;
    localparam int STATE_W = 5;
    localparam int SYM_W   = 7;
    localparam int NEXT_W  = 6;
    localparam int VERD_W  = 2;
    localparam int ERR_W   = 2;

    localparam logic [CMD_W-1:0] CMD_WR_TRANS  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WR_ACCEPT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WR_ALPHA  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SYMBOL    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_END       = 3'd4;

    localparam logic [VERD_W-1:0] VERD_ACCEPT     = 2'd0;
    localparam logic [VERD_W-1:0] VERD_REJECT     = 2'd1;
    localparam logic [VERD_W-1:0] VERD_BAD_SYMBOL = 2'd2;
    localparam logic [VERD_W-1:0] VERD_BAD_RULE   = 2'd3;

    localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_SYMBOL = 2'd2;
    localparam logic [ERR_W-1:0] ERR_BAD_RULE   = 2'd3;

    // One word held in the input register, with its table lookups.
    typedef struct packed {
        logic              vld;
        logic [CMD_W-1:0]  cmd;
        logic [SYM_W-1:0]  sym;
        logic              sym_ok;
        logic [NEXT_W-1:0] rdata;
        logic              acc_flag;
    } t_stage;

endpackage

[sv/dsa_front.sv]
// Input register, table stores and lookups of the automaton.
`include "assert_macros.svh"

module dsa_front import dsa_pkg::*; #(
    parameter int NUM_STATES   = 32,
    parameter int SYMBOL_CODES = 128,
    localparam int SW = $clog2(NUM_STATES),
    localparam int YW = $clog2(SYMBOL_CODES)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic [STATE_W-1:0]       i_state_index,
    input  logic [SYM_W-1:0]         i_symbol,
    input  logic signed [NEXT_W-1:0] i_next_state,
    input  logic                     i_flag,
    input  logic [SW-1:0]            i_cur_state,
    input  logic                     i_advance,
    output t_stage                   o_stage
);

    localparam int DEPTH = 2 ** (SW + YW);

    logic [NEXT_W-1:0] mem_trans [0:DEPTH-1];
    logic              mem_alpha [0:SYMBOL_CODES-1];
    logic              r_alpha_vld [0:SYMBOL_CODES-1];
    logic              r_accept [0:NUM_STATES-1];

    logic              r_vld;
    logic [CMD_W-1:0]  r_cmd;
    logic [SYM_W-1:0]  r_sym;
    logic              r_sym_live;
    logic              r_alpha_rd;
    logic [NEXT_W-1:0] r_rdata;
    logic              r_acc_flag;

    logic          w_acc;
    logic          w_st_ok;
    logic          w_sym_ok;
    logic [SW-1:0] w_st_idx;
    logic [YW-1:0] w_sym_idx;
    logic          w_is_sym;

    assign o_ready   = !r_vld || i_advance;
    assign w_acc     = i_valid && o_ready;
    assign w_st_ok   = 32'(i_state_index) < NUM_STATES;
    assign w_sym_ok  = 32'(i_symbol) < SYMBOL_CODES;
    assign w_st_idx  = SW'(i_state_index);
    assign w_sym_idx = YW'(i_symbol);
    assign w_is_sym  = (i_cmd == CMD_SYMBOL);

    // Transition table: one port, written by loads, read by symbols.
    always_ff @(posedge i_clk) begin
        if (w_acc && i_cmd == CMD_WR_TRANS && w_st_ok && w_sym_ok) begin
            mem_trans[{w_st_idx, w_sym_idx}] <= i_next_state;
        end else if (w_acc && w_is_sym) begin
            r_rdata <= mem_trans[{i_cur_state, w_sym_idx}];
        end
    end

    // Alphabet bits: data in memory, cleared state through valid flags.
    always_ff @(posedge i_clk) begin
        if (w_acc && i_cmd == CMD_WR_ALPHA && w_sym_ok) begin
            mem_alpha[w_sym_idx] <= i_flag;
        end else if (w_acc && w_is_sym && w_sym_ok) begin
            r_alpha_rd <= mem_alpha[w_sym_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SYMBOL_CODES; i++) begin
                r_alpha_vld[i] <= 1'b0;
            end
        end else if (w_acc && i_cmd == CMD_WR_ALPHA && w_sym_ok) begin
            r_alpha_vld[w_sym_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_STATES; i++) begin
                r_accept[i] <= 1'b0;
            end
        end else if (w_acc && i_cmd == CMD_WR_ACCEPT && w_st_ok) begin
            r_accept[w_st_idx] <= i_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    // Capture payload and the lookups that go with it.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cmd      <= i_cmd;
            r_sym      <= i_symbol;
            r_sym_live <= w_sym_ok && r_alpha_vld[w_sym_idx];
            r_acc_flag <= r_accept[i_cur_state];
        end
    end

    assign o_stage = '{vld:      r_vld,
                       cmd:      r_cmd,
                       sym:      r_sym,
                       sym_ok:   r_sym_live && r_alpha_rd,
                       rdata:    r_rdata,
                       acc_flag: r_acc_flag};

    `ASSERT_NEXT(a_stage_holds, (r_vld && !i_advance), (r_vld && $stable(r_cmd)), "stalled word lost")

endmodule

[sv/dsa_walk.sv]
// State walk, error latch and verdict output register of the automaton.
`include "assert_macros.svh"

module dsa_walk import dsa_pkg::*; #(
    parameter int NUM_STATES = 32,
    localparam int SW = $clog2(NUM_STATES)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_stage              i_stage,
    output logic                o_advance,
    output logic [SW-1:0]       o_next_state,
    output logic                o_m_valid,
    input  logic                i_m_ready,
    output logic [VERD_W-1:0]   o_verdict,
    output logic [STATE_W-1:0]  o_final_state,
    output logic [SYM_W-1:0]    o_bad_symbol
);

    logic [SW-1:0]      r_cur_state, n_cur_state;
    logic [ERR_W-1:0]   r_err, n_err;
    logic [SYM_W-1:0]   r_offend, n_offend;
    logic               r_m_valid;
    logic [VERD_W-1:0]  r_verdict, n_verdict;
    logic [STATE_W-1:0] r_final;
    logic [SYM_W-1:0]   r_bad, n_bad;

    logic w_is_end;
    logic w_bad_rule;

    assign w_is_end   = i_stage.vld && (i_stage.cmd == CMD_END);
    assign o_advance  = i_stage.vld && (!w_is_end || !r_m_valid || i_m_ready);
    assign w_bad_rule = i_stage.rdata[NEXT_W-1] || (32'(i_stage.rdata) >= NUM_STATES);

    always_comb begin
        n_cur_state = r_cur_state;
        n_err       = r_err;
        n_offend    = r_offend;
        if (o_advance) begin
            unique case (i_stage.cmd)
                CMD_SYMBOL: begin
                    if (r_err == ERR_NONE) begin
                        if (!i_stage.sym_ok) begin
                            n_err    = ERR_BAD_SYMBOL;
                            n_offend = i_stage.sym;
                        end else if (w_bad_rule) begin
                            n_err = ERR_BAD_RULE;
                        end else begin
                            n_cur_state = SW'(i_stage.rdata);
                        end
                    end
                end
                CMD_END: begin
                    n_cur_state = '0;
                    n_err       = ERR_NONE;
                    n_offend    = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_bad = '0;
        if (r_err == ERR_BAD_SYMBOL) begin
            n_verdict = VERD_BAD_SYMBOL;
            n_bad     = r_offend;
        end else if (r_err == ERR_BAD_RULE) begin
            n_verdict = VERD_BAD_RULE;
        end else begin
            n_verdict = i_stage.acc_flag ? VERD_ACCEPT : VERD_REJECT;
        end
    end

    assign o_next_state = n_cur_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_state <= '0;
            r_err       <= ERR_NONE;
            r_offend    <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            r_cur_state <= n_cur_state;
            r_err       <= n_err;
            r_offend    <= n_offend;
            if (w_is_end && o_advance) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_is_end && o_advance) begin
            r_verdict <= n_verdict;
            r_final   <= STATE_W'(r_cur_state);
            r_bad     <= n_bad;
        end
    end

    assign o_m_valid     = r_m_valid;
    assign o_verdict     = r_verdict;
    assign o_final_state = r_final;
    assign o_bad_symbol  = r_bad;

    `ASSERT_NEXT(a_err_freezes, (r_err != ERR_NONE && !(w_is_end && o_advance)), (r_err == $past(r_err) && r_cur_state == $past(r_cur_state)), "walk moved after error")
    `ASSERT_NEXT(a_end_restarts, (w_is_end && o_advance), (r_cur_state == '0 && r_err == ERR_NONE && r_m_valid), "end word did not restart")
    `ASSERT_CLK(a_bad_zero, (!r_m_valid || r_verdict == VERD_BAD_SYMBOL || r_bad == '0), "bad symbol set on other verdict")
    `ASSERT_CLK(a_state_range, (32'(r_cur_state) < NUM_STATES), "state out of range")

endmodule

[sv/dfa_string_acceptor.sv]
// Top level of the table-driven string acceptor.
// An end word passes the input register; its verdict then lands in the output register.
// Throughput: one word per cycle unless stalled; next state forms the table address.
// Reset: synchronous active low; clears walk state, accept flags and alphabet valid bits.
// The transition table has no reset and holds garbage until written; no clearing pass.
// Back pressure: a stalled verdict holds one end word in the input register.
module dfa_string_acceptor import dsa_pkg::*; #(
    parameter int NUM_STATES   = 32,
    parameter int SYMBOL_CODES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [4:0] state_index, [11:5] symbol, [17:12] next_state, [18] flag, [23:19] zero
    input  logic [23:0] i_s_axis_tdata,
    // [2:0] cmd
    input  logic [2:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [1:0] verdict, [6:2] final_state, [13:7] bad_symbol, [15:14] zero
    output logic [15:0] o_m_axis_tdata
);

    localparam int SW = $clog2(NUM_STATES);

    t_stage               w_stage;
    logic                 w_advance;
    logic [SW-1:0]        w_next_state;
    logic [VERD_W-1:0]    w_verdict;
    logic [STATE_W-1:0]   w_final_state;
    logic [SYM_W-1:0]     w_bad_symbol;

    // Front: register each word; loads write the stores at once, symbols
    // launch their table read with the state the walk is about to hold.
    dsa_front #(
        .NUM_STATES   (NUM_STATES),
        .SYMBOL_CODES (SYMBOL_CODES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_cmd         (i_s_axis_tuser),
        .i_state_index (i_s_axis_tdata[4:0]),
        .i_symbol      (i_s_axis_tdata[11:5]),
        .i_next_state  (i_s_axis_tdata[17:12]),
        .i_flag        (i_s_axis_tdata[18]),
        .i_cur_state   (w_next_state),
        .i_advance     (w_advance),
        .o_stage       (w_stage)
    );

    // Walk: advance the state, latch the first error, emit the verdict
    // into the output register on end of string.
    dsa_walk #(
        .NUM_STATES (NUM_STATES)
    ) u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stage       (w_stage),
        .o_advance     (w_advance),
        .o_next_state  (w_next_state),
        .o_m_valid     (o_m_axis_tvalid),
        .i_m_ready     (i_m_axis_tready),
        .o_verdict     (w_verdict),
        .o_final_state (w_final_state),
        .o_bad_symbol  (w_bad_symbol)
    );

    // Pack the result word, lowest field first.
    assign o_m_axis_tdata = {2'b00, w_bad_symbol, w_final_state, w_verdict};

endmodule
